// ===== src/mpts_pkg.sv =====
// ----------------------------------------------------------------------------
// mpts_pkg
// Shared types, constants and helper functions for the memory pattern test
// sequencer.
// ----------------------------------------------------------------------------
package mpts_pkg;

  localparam int unsigned MAX_TEST_WORDS = 8388608;
  localparam int unsigned PATTERN_LENGTH = 5;

  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned WORDS_W   = 24;
  localparam int unsigned COUNT_W   = 23;
  localparam int unsigned STAGE_W   = 3;
  localparam int unsigned PIDX_W    = 3;
  localparam int unsigned OUT_W     = 104;

  localparam logic [WORDS_W-1:0] RESET_TEST_WORDS = WORDS_W'(4096);
  localparam logic [WORDS_W-1:0] MAX_WORDS        = WORDS_W'(MAX_TEST_WORDS);
  localparam logic [STAGE_W-1:0] STAGE_LAST       = 3'd7;
  localparam logic [PIDX_W-1:0]  PIDX_LAST        = PIDX_W'(PATTERN_LENGTH - 1);

  // configuration register indexes
  typedef enum logic {
    REG_BASE_ADDRESS = 1'b0,
    REG_TEST_WORDS   = 1'b1
  } reg_index_t;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  base_address;
    logic [WORDS_W-1:0] eff_words;
    logic [PIDX_W-1:0]  start_index;
  } cfg_t;

  typedef struct packed {
    logic               access_valid;
    logic               access_is_write;
    logic [ADDR_W-1:0]  access_address;
    logic [DATA_W-1:0]  write_word;
    logic [STAGE_W-1:0] current_stage;
    logic               finished;
    logic               mismatch;
    logic [ADDR_W-1:0]  failing_address;
  } result_t;

  // region size clamped into 1 .. MAX_TEST_WORDS
  function automatic logic [WORDS_W-1:0] eff_words_of(logic [WORDS_W-1:0] w);
    logic [WORDS_W-1:0] r;
    r = w;
    if (w == '0) begin
      r = WORDS_W'(1);
    end else if (w > MAX_WORDS) begin
      r = MAX_WORDS;
    end
    return r;
  endfunction

  // (4 * w) mod 5; hex digits sum to the value mod 5 since 16 = 1 mod 5
  function automatic logic [PIDX_W-1:0] start_index_of(logic [WORDS_W-1:0] w);
    logic [6:0] s;
    logic [4:0] t;
    logic [2:0] r;
    s = 7'(w[3:0]) + 7'(w[7:4]) + 7'(w[11:8]) + 7'(w[15:12])
      + 7'(w[19:16]) + 7'(w[23:20]);
    t = 5'(s[6:4]) + 5'(s[3:0]);
    if (t >= 5'd20) t = t - 5'd20;
    if (t >= 5'd10) t = t - 5'd10;
    if (t >= 5'd5)  t = t - 5'd5;
    r = t[2:0];
    return (r == 3'd0) ? 3'd0 : 3'(3'd5 - r);
  endfunction

  function automatic logic [DATA_W-1:0] pattern_word(logic [1:0] kind,
                                                     logic [PIDX_W-1:0] idx);
    logic [DATA_W-1:0] w;
    w = '0;
    case (kind)
      2'd0: w = 32'h0000_0000;
      2'd1: w = 32'hffff_ffff;
      2'd2: begin
        case (idx)
          3'd0:    w = 32'h2468_ace0;
          3'd1:    w = 32'h1357_9bde;
          3'd2:    w = 32'h1234_5678;
          3'd3:    w = 32'h9abc_def0;
          3'd4:    w = 32'h1122_3344;
          default: w = '0;
        endcase
      end
      default: begin
        case (idx)
          3'd0:    w = 32'hff55_ccaa;
          3'd1:    w = 32'h00ff_55cc;
          3'd2:    w = 32'haa00_ff55;
          3'd3:    w = 32'hccaa_00ff;
          3'd4:    w = 32'h55cc_aa00;
          default: w = '0;
        endcase
      end
    endcase
    return w;
  endfunction

endpackage

// ===== src/mpts_cfg.sv =====
// ----------------------------------------------------------------------------
// mpts_cfg
// Configuration registers; keeps the clamped region size and the pass start
// column ready so the sequencer never works them out per word.
// ----------------------------------------------------------------------------
module mpts_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_index,
  input  logic [mpts_pkg::DATA_W-1:0]     cfg_data,
  output mpts_pkg::cfg_t                  cfg
);

  logic [mpts_pkg::ADDR_W-1:0]  base_address;
  logic [mpts_pkg::WORDS_W-1:0] eff_words;
  logic [mpts_pkg::PIDX_W-1:0]  start_index;
  logic [mpts_pkg::WORDS_W-1:0] words_in;

  assign cfg_ready = 1'b1;
  assign words_in  = mpts_pkg::eff_words_of(cfg_data[mpts_pkg::WORDS_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
      eff_words    <= mpts_pkg::eff_words_of(mpts_pkg::RESET_TEST_WORDS);
      start_index  <= mpts_pkg::start_index_of(
                        mpts_pkg::eff_words_of(mpts_pkg::RESET_TEST_WORDS));
    end else if (cfg_valid) begin
      unique case (mpts_pkg::reg_index_t'(cfg_index))
        mpts_pkg::REG_BASE_ADDRESS: base_address <= cfg_data;
        mpts_pkg::REG_TEST_WORDS: begin
          eff_words   <= words_in;
          start_index <= mpts_pkg::start_index_of(words_in);
        end
        default: ;
      endcase
    end
  end

  assign cfg.base_address = base_address;
  assign cfg.eff_words    = eff_words;
  assign cfg.start_index  = start_index;

endmodule

// ===== src/mpts_core.sv =====
// ----------------------------------------------------------------------------
// mpts_core
// Sequencer state and the per-word next-state logic: verify compare, word and
// stage advance, address and pattern generation.
// ----------------------------------------------------------------------------
module mpts_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  logic                        op,
  input  logic [mpts_pkg::DATA_W-1:0] read_word,
  input  mpts_pkg::cfg_t              cfg,
  output mpts_pkg::result_t           result
);

  logic                          running, running_next;
  logic [mpts_pkg::STAGE_W-1:0]  stage, stage_next;
  logic [mpts_pkg::COUNT_W-1:0]  word_counter, word_counter_next;
  logic [mpts_pkg::PIDX_W-1:0]   pattern_index, pattern_index_next;
  logic                          check_pending, check_pending_next;
  logic [mpts_pkg::ADDR_W-1:0]   pending_address, pending_address_next;
  logic [mpts_pkg::DATA_W-1:0]   pending_expected, pending_expected_next;
  logic                          failed_flag, failed_flag_next;
  logic [mpts_pkg::ADDR_W-1:0]   first_fail_address, first_fail_address_next;
  logic                          done_flag, done_flag_next;

  logic                          do_issue;
  logic [mpts_pkg::ADDR_W-1:0]   issue_addr;
  logic [mpts_pkg::DATA_W-1:0]   issue_word;
  logic                          issue_wr;
  logic                          last_word;

  always_comb begin
    running_next            = running;
    stage_next              = stage;
    word_counter_next       = word_counter;
    pattern_index_next      = pattern_index;
    check_pending_next      = check_pending;
    pending_address_next    = pending_address;
    pending_expected_next   = pending_expected;
    failed_flag_next        = failed_flag;
    first_fail_address_next = first_fail_address;
    done_flag_next          = done_flag;
    do_issue                = 1'b0;
    last_word = ({1'b0, word_counter} + mpts_pkg::WORDS_W'(1)) >= cfg.eff_words;

    if (mpts_pkg::op_t'(op) == mpts_pkg::OP_START) begin
      failed_flag_next        = 1'b0;
      done_flag_next          = 1'b0;
      first_fail_address_next = '0;
      check_pending_next      = 1'b0;
      pending_address_next    = '0;
      pending_expected_next   = '0;
      stage_next              = '0;
      word_counter_next       = '0;
      pattern_index_next      = cfg.start_index;
      running_next            = 1'b1;
      do_issue                = 1'b1;
    end else if (running) begin
      check_pending_next = 1'b0;
      if (check_pending && (read_word != pending_expected)) begin
        failed_flag_next        = 1'b1;
        first_fail_address_next = pending_address;
        done_flag_next          = 1'b1;
        running_next            = 1'b0;
      end else if (last_word) begin
        if (stage == mpts_pkg::STAGE_LAST) begin
          running_next   = 1'b0;
          done_flag_next = 1'b1;
        end else begin
          stage_next         = stage + 3'd1;
          word_counter_next  = '0;
          pattern_index_next = cfg.start_index;
          do_issue           = 1'b1;
        end
      end else begin
        word_counter_next  = word_counter + mpts_pkg::COUNT_W'(1);
        pattern_index_next = (pattern_index == mpts_pkg::PIDX_LAST) ? '0
                                                                   : pattern_index + 3'd1;
        do_issue           = 1'b1;
      end
    end

    issue_addr = {cfg.base_address[mpts_pkg::ADDR_W-1:2], 2'b00}
               + {7'b0, word_counter_next, 2'b00};
    issue_word = mpts_pkg::pattern_word(stage_next[2:1], pattern_index_next);
    issue_wr   = !stage_next[0];
    if (do_issue && !issue_wr) begin
      check_pending_next    = 1'b1;
      pending_address_next  = issue_addr;
      pending_expected_next = issue_word;
    end

    result.current_stage = stage_next;
    if (do_issue) begin
      result.access_valid    = 1'b1;
      result.access_is_write = issue_wr;
      result.access_address  = issue_addr;
      result.write_word      = issue_wr ? issue_word : '0;
      result.finished        = 1'b0;
      result.mismatch        = 1'b0;
      result.failing_address = '0;
    end else begin
      result.access_valid    = 1'b0;
      result.access_is_write = 1'b0;
      result.access_address  = '0;
      result.write_word      = '0;
      result.finished        = done_flag_next;
      result.mismatch        = failed_flag_next;
      result.failing_address = first_fail_address_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running            <= 1'b0;
      stage              <= '0;
      word_counter       <= '0;
      pattern_index      <= '0;
      check_pending      <= 1'b0;
      pending_address    <= '0;
      pending_expected   <= '0;
      failed_flag        <= 1'b0;
      first_fail_address <= '0;
      done_flag          <= 1'b0;
    end else if (advance) begin
      running            <= running_next;
      stage              <= stage_next;
      word_counter       <= word_counter_next;
      pattern_index      <= pattern_index_next;
      check_pending      <= check_pending_next;
      pending_address    <= pending_address_next;
      pending_expected   <= pending_expected_next;
      failed_flag        <= failed_flag_next;
      first_fail_address <= first_fail_address_next;
      done_flag          <= done_flag_next;
    end
  end

  // a verify read is only ever outstanding inside a live run
  a_pending_needs_run: assert property (@(posedge clk) disable iff (rst)
    check_pending |-> running)
    else $error("verify read pending with no run active");

  a_done_stops_run: assert property (@(posedge clk) disable iff (rst)
    done_flag |-> !running)
    else $error("run still active after it finished");

  a_fail_implies_done: assert property (@(posedge clk) disable iff (rst)
    failed_flag |-> done_flag)
    else $error("mismatch flagged without the run finishing");

  a_start_restarts: assert property (@(posedge clk) disable iff (rst)
    (advance && (mpts_pkg::op_t'(op) == mpts_pkg::OP_START))
      |=> (running && (stage == '0) && (word_counter == '0)))
    else $error("start did not restart the sequence");

  a_pattern_in_range: assert property (@(posedge clk) disable iff (rst)
    pattern_index <= mpts_pkg::PIDX_LAST)
    else $error("pattern column out of range");

endmodule

// ===== src/memory_pattern_test_sequencer.sv =====
// an input word passes through the input register, then its result through the result register
// throughput: one word per cycle while m_tready holds, a result may wait while the next is taken
// the input register and the result register each hold one word
// reset clears the run state and flags; base_address resets to 0 and
// test_words to 4096
// ----------------------------------------------------------------------------
// memory_pattern_test_sequencer
// Memory self-test sequencer: write then verify four patterns over a
// region, at most one access per result.
// ----------------------------------------------------------------------------
module memory_pattern_test_sequencer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [31:0]                   s_tdata,  // read_word
  input  logic [0:0]                    s_tuser,  // op
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // access_valid, access_is_write, access_address[31:0], write_word[31:0],
  // current_stage[2:0], finished, mismatch, failing_address[31:0], pad
  output logic [mpts_pkg::OUT_W-1:0]    m_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [31:0]                   cfg_data
);

  logic                        in_valid;
  logic                        in_op;
  logic [mpts_pkg::DATA_W-1:0] in_read_word;
  logic                        advance;
  logic                        out_valid;
  logic [mpts_pkg::OUT_W-1:0]  out_data;
  mpts_pkg::cfg_t              cfg;
  mpts_pkg::result_t           result;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_op        <= s_tuser[0];
      in_read_word <= s_tdata;
    end
  end

  mpts_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mpts_core u_core (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .op        (in_op),
    .read_word (in_read_word),
    .cfg       (cfg),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= {1'b0,
                   result.failing_address,
                   result.mismatch,
                   result.finished,
                   result.current_stage,
                   result.write_word,
                   result.access_address,
                   result.access_is_write,
                   result.access_valid};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule
